// ===== hdl/spsl_pkg.sv =====
// ----------------------------------------------------------------------------
// Speed PID package
// Widths, register indexes, controller states and the command and status
// structures shared by the speed PID controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package spsl_pkg;

   localparam int SPEED_W     = 16;
   localparam int ERR_W       = SPEED_W + 1;
   localparam int DERR_W      = ERR_W + 1;
   localparam int GAIN_W      = 24;
   localparam int PERIOD_W    = 16;
   localparam int LIMIT_W     = 15;
   localparam int ACC_W       = 29;
   localparam int ACC_SUM_W   = 34;
   localparam int MUL_A_W     = 25;
   localparam int MUL_B_W     = 30;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int GAIN_FRAC   = 12;
   localparam int PERIOD_FRAC = 16;
   localparam int P_W         = 30;
   localparam int I_W         = 26;
   localparam int DMAG_W      = 42;
   localparam int DSCALE      = PERIOD_FRAC - GAIN_FRAC;
   localparam int DIV_W       = DMAG_W + DSCALE;
   localparam int DIV_BITS    = 2;
   localparam int DIV_ITER    = DIV_W / DIV_BITS;
   localparam int DIV_CNT_W   = $clog2(DIV_ITER + 1);
   localparam int REM_W       = PERIOD_W + 1;
   localparam int SUM_W       = 49;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic signed [ACC_SUM_W-1:0] INTEG_BOUND = 34'sd131072000;
   localparam logic signed [ERR_W-1:0]     KICK_BAND   = 17'sd10;
   localparam logic [SPEED_W:0]            LOW_SPEED   = 17'd4000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN    = 3'd0,
      CSR_INTEG_GAIN   = 3'd1,
      CSR_DERIV_GAIN   = 3'd2,
      CSR_SAMPLE_PER   = 3'd3,
      CSR_OUTPUT_LIMIT = 3'd4,
      CSR_SLEW_LIMIT   = 3'd5,
      CSR_START_KICK   = 3'd6,
      CSR_INCR_MODE    = 3'd7
   } csr_index_type;

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b00_0000_0001,
      ST_MUL_P    = 10'b00_0000_0010,
      ST_MUL_STEP = 10'b00_0000_0100,
      ST_ACC      = 10'b00_0000_1000,
      ST_MUL_I    = 10'b00_0001_0000,
      ST_MUL_D    = 10'b00_0010_0000,
      ST_DIV_LOAD = 10'b00_0100_0000,
      ST_DIV      = 10'b00_1000_0000,
      ST_SUM      = 10'b01_0000_0000,
      ST_OUT      = 10'b10_0000_0000
   } state_type;

   typedef enum logic [1:0] {
      MUL_PROP  = 2'd0,
      MUL_STEP  = 2'd1,
      MUL_INTEG = 2'd2,
      MUL_DERIV = 2'd3
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        p_cap;
      logic        acc_upd;
      logic        i_cap;
      logic        div_start;
      logic        div_step;
      logic        sum_en;
      logic        out_en;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } sts_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] prop_gain;
      logic signed [GAIN_W-1:0] integ_gain;
      logic signed [GAIN_W-1:0] deriv_gain;
      logic [PERIOD_W-1:0]      sample_period;
      logic [LIMIT_W-1:0]       output_limit;
      logic [LIMIT_W-1:0]       slew_limit;
      logic [LIMIT_W-1:0]       start_kick;
      logic                     incremental_mode;
   } cfg_type;

endpackage

`default_nettype wire

// ===== hdl/spsl_ctrl.sv =====
// ----------------------------------------------------------------------------
// Speed PID controller
// Sequences the datapath through the terms of one sample and owns the
// handshakes of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module spsl_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire spsl_pkg::sts_type sts,
   output spsl_pkg::cmd_type     cmd
);
   import spsl_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.mul_sel   = MUL_PROP;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = ST_MUL_P;
            end
         end
         ST_MUL_P: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_PROP;
            state_in    = ST_MUL_STEP;
         end
         ST_MUL_STEP: begin
            cmd.p_cap   = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_STEP;
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_upd = 1'b1;
            state_in    = ST_MUL_I;
         end
         ST_MUL_I: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_INTEG;
            state_in    = ST_MUL_D;
         end
         ST_MUL_D: begin
            cmd.i_cap   = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DERIV;
            state_in    = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_SUM;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_en   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_out_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_en |-> (!rsp_valid_ff || rsp_ready))
      else $error("Result beat overwritten while still pending.");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_MUL_P))
      else $error("Accepted beat did not start the sequence.");

   a_out_gives_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_en |=> rsp_valid_ff)
      else $error("Finished sample produced no result beat.");

   a_div_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !sts.div_done)
      else $error("Divider stepped past its last iteration.");

endmodule

`default_nettype wire

// ===== hdl/spsl_dp.sv =====
// ----------------------------------------------------------------------------
// Speed PID datapath
// Shared multiplier, integral accumulator, radix-4 divider for the
// derivative term, output clamp and slew limiter.
// ----------------------------------------------------------------------------
`default_nettype none

module spsl_dp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire spsl_pkg::cfg_type                  cfg,
   input  wire spsl_pkg::cmd_type                  cmd,
   output spsl_pkg::sts_type                       sts,
   input  wire logic signed [spsl_pkg::SPEED_W-1:0] req_target_speed,
   input  wire logic signed [spsl_pkg::SPEED_W-1:0] req_measured_speed,
   output logic signed [spsl_pkg::SPEED_W-1:0]     rsp_drive_value
);
   import spsl_pkg::*;

   logic signed [SPEED_W-1:0] meas_ff;
   logic                      tgt_zero_ff;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [DERR_W-1:0]  derr_ff, derr_in;
   logic signed [ERR_W-1:0]   prev_err_ff;
   logic signed [SPEED_W-1:0] prev_out_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [P_W-1:0]     p_ff;
   logic signed [I_W-1:0]     i_ff;
   logic signed [PROD_W-1:0]  p_adj, i_adj, prod_mag;
   logic signed [ACC_SUM_W-1:0] acc_sum;
   logic                      d_neg_ff;
   logic [DIV_W-1:0]          quo_ff, quo_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]      cnt_ff;
   logic signed [DIV_W:0]     d_val;
   logic signed [SUM_W-1:0]   sum, extra, lim_s;
   logic signed [ERR_W-1:0]   kick;
   logic signed [SPEED_W-1:0] desired_ff;
   logic signed [SPEED_W-1:0] rsp_data_ff;
   logic                      clamped;
   logic signed [SPEED_W-1:0] desired_in;
   logic [SPEED_W:0]          meas_mag;
   logic [LIMIT_W-1:0]        slew;
   logic signed [SPEED_W+1:0] hi, lo, outv;
   logic signed [SPEED_W-1:0] out_in;

   assign err_in  = ERR_W'(req_target_speed) - ERR_W'(req_measured_speed);
   assign derr_in = DERR_W'(err_in) - DERR_W'(prev_err_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.mul_sel)
         MUL_PROP: begin
            mul_a = MUL_A_W'(cfg.prop_gain);
            mul_b = MUL_B_W'(err_ff);
         end
         MUL_STEP: begin
            mul_a = $signed({{(MUL_A_W-PERIOD_W){1'b0}}, cfg.sample_period});
            mul_b = MUL_B_W'(err_ff);
         end
         MUL_INTEG: begin
            mul_a = MUL_A_W'(cfg.integ_gain);
            mul_b = MUL_B_W'(acc_ff);
         end
         MUL_DERIV: begin
            mul_a = MUL_A_W'(cfg.deriv_gain);
            mul_b = MUL_B_W'(derr_ff);
         end
         default: begin
            mul_a = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   assign p_adj = prod_ff + (prod_ff[PROD_W-1] ?
                  PROD_W'((1 << GAIN_FRAC) - 1) : PROD_W'(0));
   assign i_adj = prod_ff + (prod_ff[PROD_W-1] ?
                  PROD_W'((1 << (GAIN_FRAC + PERIOD_FRAC)) - 1) : PROD_W'(0));
   assign prod_mag = prod_ff[PROD_W-1] ? -prod_ff : prod_ff;
   assign acc_sum  = ACC_SUM_W'(acc_ff) + prod_ff[ACC_SUM_W-1:0];

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      for (int k = 0; k < DIV_BITS; k++) begin
         rem_in = {rem_in[REM_W-2:0], quo_in[DIV_W-1]};
         quo_in = {quo_in[DIV_W-2:0], 1'b0};
         if (rem_in >= {1'b0, cfg.sample_period}) begin
            rem_in    = rem_in - {1'b0, cfg.sample_period};
            quo_in[0] = 1'b1;
         end
      end
   end

   assign sts.div_done = (cnt_ff == DIV_CNT_W'(DIV_ITER));

   always_comb begin
      if (cfg.sample_period == '0) begin
         d_val = '0;
      end else if (d_neg_ff) begin
         d_val = -$signed({1'b0, quo_ff});
      end else begin
         d_val = $signed({1'b0, quo_ff});
      end
      if (err_ff > KICK_BAND) begin
         kick = $signed({2'b00, cfg.start_kick});
      end else if (err_ff < -KICK_BAND) begin
         kick = -$signed({2'b00, cfg.start_kick});
      end else begin
         kick = '0;
      end
      extra = cfg.incremental_mode ? SUM_W'(prev_out_ff) : SUM_W'(kick);
      sum   = SUM_W'(p_ff) + SUM_W'(i_ff) + SUM_W'(d_val) + extra;
      lim_s = $signed({{(SUM_W-LIMIT_W){1'b0}}, cfg.output_limit});
      clamped = 1'b1;
      if (sum > lim_s) begin
         desired_in = SPEED_W'(lim_s);
      end else if (sum < -lim_s) begin
         desired_in = SPEED_W'(-lim_s);
      end else begin
         desired_in = SPEED_W'(sum);
         clamped    = 1'b0;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      priority if (cmd.sum_en && clamped) begin
         acc_in = '0;
      end else if (cmd.acc_upd) begin
         if (acc_sum > INTEG_BOUND) begin
            acc_in = ACC_W'(INTEG_BOUND);
         end else if (acc_sum < -INTEG_BOUND) begin
            acc_in = ACC_W'(-INTEG_BOUND);
         end else begin
            acc_in = ACC_W'(acc_sum);
         end
      end
   end

   always_comb begin
      meas_mag = meas_ff[SPEED_W-1] ? (SPEED_W + 1)'(-(SPEED_W + 1)'(meas_ff))
                                     : (SPEED_W + 1)'(meas_ff);
      slew = (meas_mag <= LOW_SPEED) ? (cfg.slew_limit >> 1) : cfg.slew_limit;
      hi   = (SPEED_W + 2)'(prev_out_ff) + $signed({3'b000, slew});
      lo   = (SPEED_W + 2)'(prev_out_ff) - $signed({3'b000, slew});
      if ((SPEED_W + 2)'(desired_ff) > hi) begin
         outv = hi;
      end else if ((SPEED_W + 2)'(desired_ff) < lo) begin
         outv = lo;
      end else begin
         outv = (SPEED_W + 2)'(desired_ff);
      end
      out_in = (cfg.incremental_mode && tgt_zero_ff) ? '0 : SPEED_W'(outv);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         meas_ff     <= req_measured_speed;
         tgt_zero_ff <= (req_target_speed == '0);
         err_ff      <= err_in;
         derr_ff     <= derr_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.p_cap) begin
         p_ff <= P_W'(p_adj >>> GAIN_FRAC);
      end
      if (cmd.i_cap) begin
         i_ff <= I_W'(i_adj >>> (GAIN_FRAC + PERIOD_FRAC));
      end
      if (cmd.div_start) begin
         d_neg_ff <= prod_ff[PROD_W-1];
         quo_ff   <= {prod_mag[DMAG_W-1:0], {DSCALE{1'b0}}};
         rem_ff   <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (cmd.sum_en) begin
         desired_ff <= desired_in;
      end
      if (cmd.out_en) begin
         rsp_data_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         prev_err_ff <= '0;
         prev_out_ff <= '0;
         cnt_ff      <= '0;
      end else begin
         acc_ff <= acc_in;
         if (cmd.div_start) begin
            cnt_ff <= '0;
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.out_en) begin
            prev_err_ff <= err_ff;
            prev_out_ff <= out_in;
         end
      end
   end

   assign rsp_drive_value = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hdl/speed_pid_slew_limited_core.sv =====
// ----------------------------------------------------------------------------
// Speed PID with anti-windup and slew limit
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// Each request beat carries a target and a measured speed; each produces
// exactly one response beat with the new drive value.
// Both channels use valid and ready. The user must write registers through
// the csr port only while the block is idle; the block itself does not
// enforce this. Written values take effect from the next sample.
// From acceptance a sample forms the four products on the shared 25 by 30
// bit multiplier and updates the integral, loads the divider, runs the
// radix-4 divider that forms the derivative term in 23 steps and then
// clamps and slew-limits the result before its response beat is offered.
// A new request is accepted in the cycle after the response is registered,
// so the block works one sample at a time.
// A pending response is held in an output register; the next sample may be
// accepted and worked while it waits, and only its final store stalls.
// Reset clears the integral, the previous error and output and loads the
// default register values.
// ----------------------------------------------------------------------------
`default_nettype none

module speed_pid_slew_limited_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [spsl_pkg::SPEED_W-1:0]    req_target_speed,
   input  wire logic signed [spsl_pkg::SPEED_W-1:0]    req_measured_speed,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [spsl_pkg::SPEED_W-1:0]         rsp_drive_value,
   input  wire logic                                   csr_write_enable,
   input  wire logic [spsl_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [spsl_pkg::CSR_DATA_W-1:0]        csr_write_data
);
   import spsl_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;
   sts_type sts;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_PROP_GAIN:    cfg_in.prop_gain     = csr_write_data[GAIN_W-1:0];
            CSR_INTEG_GAIN:   cfg_in.integ_gain    = csr_write_data[GAIN_W-1:0];
            CSR_DERIV_GAIN:   cfg_in.deriv_gain    = csr_write_data[GAIN_W-1:0];
            CSR_SAMPLE_PER:   cfg_in.sample_period = csr_write_data[PERIOD_W-1:0];
            CSR_OUTPUT_LIMIT: cfg_in.output_limit  = csr_write_data[LIMIT_W-1:0];
            CSR_SLEW_LIMIT:   cfg_in.slew_limit    = csr_write_data[LIMIT_W-1:0];
            CSR_START_KICK:   cfg_in.start_kick    = csr_write_data[LIMIT_W-1:0];
            CSR_INCR_MODE:    cfg_in.incremental_mode = csr_write_data[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain        <= '0;
         cfg_ff.integ_gain       <= '0;
         cfg_ff.deriv_gain       <= '0;
         cfg_ff.sample_period    <= PERIOD_W'(655);
         cfg_ff.output_limit     <= '1;
         cfg_ff.slew_limit       <= '1;
         cfg_ff.start_kick       <= '0;
         cfg_ff.incremental_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   spsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   spsl_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .cmd                (cmd),
      .sts                (sts),
      .req_target_speed   (req_target_speed),
      .req_measured_speed (req_measured_speed),
      .rsp_drive_value    (rsp_drive_value)
   );

endmodule

`default_nettype wire

// ===== tb/sv/tb_speed_pid_slew_limited_core.sv =====
// ----------------------------------------------------------------------------
// Speed PID core testbench
// Drives request beats through a directed table and then random phases
// under several register settings, predicts every drive value with a local
// fixed-point model of the controller and compares each response beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_speed_pid_slew_limited_core;
   import spsl_pkg::*;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [SPEED_W-1:0] req_target_speed;
   logic signed [SPEED_W-1:0] req_measured_speed;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [SPEED_W-1:0] rsp_drive_value;
   logic csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   speed_pid_slew_limited_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_target_speed(req_target_speed), .req_measured_speed(req_measured_speed),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_drive_value(rsp_drive_value),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   typedef struct {
      logic signed [SPEED_W-1:0] target;
      logic signed [SPEED_W-1:0] measured;
      bit                        known;
      logic signed [SPEED_W-1:0] drive;
   } sample_row_type;

   // Controller copy
   longint m_prop, m_integ, m_deriv;
   longint m_period, m_limit, m_slew, m_kick;
   bit     m_incr;
   longint m_acc, m_prev_err, m_prev_out;

   logic signed [SPEED_W-1:0] drive_queue[$];
   int errors = 0;
   int beats_sent = 0;
   int beats_checked = 0;
   int settings_used = 0;
   bit hold_rsp = 0;
   bit stim_done = 0;

   function automatic longint div_trunc(longint num, longint den);
      longint q;
      q = (num < 0 ? -num : num) / (den < 0 ? -den : den);
      return ((num < 0) != (den < 0)) ? -q : q;
   endfunction

   function automatic logic signed [SPEED_W-1:0] predict_drive(longint tgt, longint meas);
      longint err, kick, p, i, d, want, lim, mag, outv;
      err = tgt - meas;
      kick = (err < -10) ? -m_kick : (err > 10) ? m_kick : 0;
      p = div_trunc(m_prop * err, 64'sd1 << 12);
      m_acc = m_acc + err * m_period;
      if (m_acc > 131072000) m_acc = 131072000;
      if (m_acc < -131072000) m_acc = -131072000;
      i = div_trunc(m_integ * m_acc, 64'sd1 << 28);
      if (m_period == 0) d = 0;
      else d = div_trunc(m_deriv * (err - m_prev_err) * 65536, m_period * 4096);
      want = p + i + d + (m_incr ? m_prev_out : kick);
      if (want > m_limit) begin
         want = m_limit;
         m_acc = 0;
      end
      if (want < -m_limit) begin
         want = -m_limit;
         m_acc = 0;
      end
      lim = m_slew;
      mag = meas < 0 ? -meas : meas;
      if (mag <= 4000) lim = lim / 2;
      if (want > m_prev_out + lim) outv = m_prev_out + lim;
      else if (want < m_prev_out - lim) outv = m_prev_out - lim;
      else outv = want;
      if (m_incr && tgt == 0) outv = 0;
      m_prev_err = err;
      m_prev_out = outv;
      return outv[SPEED_W-1:0];
   endfunction

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("simulation failed");
      $finish;
   end

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 0;
      case (idx)
         CSR_PROP_GAIN:    m_prop = longint'($signed(val));
         CSR_INTEG_GAIN:   m_integ = longint'($signed(val));
         CSR_DERIV_GAIN:   m_deriv = longint'($signed(val));
         CSR_SAMPLE_PER:   m_period = val[15:0];
         CSR_OUTPUT_LIMIT: m_limit = val[14:0];
         CSR_SLEW_LIMIT:   m_slew = val[14:0];
         CSR_START_KICK:   m_kick = val[14:0];
         CSR_INCR_MODE:    m_incr = val[0];
         default: ;
      endcase
   endtask

   task automatic send_sample(logic signed [SPEED_W-1:0] tgt, logic signed [SPEED_W-1:0] meas,
                              bit known, logic signed [SPEED_W-1:0] drive, bit use_gaps);
      logic signed [SPEED_W-1:0] exp_drive;
      int gap;
      gap = use_gaps ? $urandom_range(0, 13) : 0;
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_target_speed <= tgt;
      req_measured_speed <= meas;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      exp_drive = predict_drive(tgt, meas);
      if (known && exp_drive !== drive) begin
         $error("table row disagrees: drive_value expected %0d predicted %0d", drive, exp_drive);
         errors++;
      end
      drive_queue.push_back(known ? drive : exp_drive);
      beats_sent++;
   endtask

   task automatic drain;
      int guard;
      guard = 0;
      req_valid <= 0;
      while (drive_queue.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
   endtask

   task automatic random_setting(bit extreme);
      write_reg(CSR_PROP_GAIN, extreme ? 24'h7FFFFF : 24'($urandom_range(0, 24'hFFFFFF)));
      write_reg(CSR_INTEG_GAIN, extreme ? 24'h800000 : 24'($urandom_range(0, 24'hFFFFFF)));
      write_reg(CSR_DERIV_GAIN, extreme ? 24'h7FFFFF : 24'($urandom_range(0, 24'hFFFFFF)));
      write_reg(CSR_SAMPLE_PER, extreme ? 24'd1 : 24'($urandom_range(0, 65535)));
      write_reg(CSR_OUTPUT_LIMIT, extreme ? 24'd32767 : 24'($urandom_range(0, 32767)));
      write_reg(CSR_SLEW_LIMIT, extreme ? 24'd0 : 24'($urandom_range(0, 32767)));
      write_reg(CSR_START_KICK, extreme ? 24'd32767 : 24'($urandom_range(0, 32767)));
      write_reg(CSR_INCR_MODE, 24'($urandom_range(0, 1)));
      settings_used++;
   endtask

   function automatic logic signed [SPEED_W-1:0] pick_speed();
      case ($urandom_range(0, 5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'($signed($urandom_range(0, 8000)) - 4000);
         3: return 16'($signed($urandom_range(0, 40)) - 20);
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin
      sample_row_type rows[$];
      logic signed [SPEED_W-1:0] base;
      reset = 1;
      req_valid = 0;
      req_target_speed = 0;
      req_measured_speed = 0;
      rsp_ready = 0;
      csr_write_enable = 0;
      csr_index = CSR_PROP_GAIN;
      csr_write_data = 0;
      m_prop = 0; m_integ = 0; m_deriv = 0; m_period = 655;
      m_limit = 32767; m_slew = 32767; m_kick = 0; m_incr = 0;
      m_acc = 0; m_prev_err = 0; m_prev_out = 0;
      repeat (4) @(posedge clock);
      reset <= 0;

      // Zero gains after reset give zero drive.
      rows.push_back('{16'sh7FFF, 16'sh8000, 1, 16'sd0});
      rows.push_back('{16'sh8000, 16'sh7FFF, 1, 16'sd0});
      rows.push_back('{16'sd0, 16'sd0, 1, 16'sd0});
      foreach (rows[k]) send_sample(rows[k].target, rows[k].measured, rows[k].known,
                                    rows[k].drive, 0);
      drain();
      rows.delete();

      // Kick band edges, clamps, slow-speed slew, zero period, incremental mode.
      write_reg(CSR_START_KICK, 24'd100);
      write_reg(CSR_SLEW_LIMIT, 24'd50);
      write_reg(CSR_PROP_GAIN, 24'h001000);
      write_reg(CSR_INTEG_GAIN, 24'h010000);
      write_reg(CSR_DERIV_GAIN, 24'h000800);
      write_reg(CSR_OUTPUT_LIMIT, 24'd300);
      rows.push_back('{16'sd10, 16'sd0, 0, 16'sd0});
      rows.push_back('{16'sd11, 16'sd0, 0, 16'sd0});
      rows.push_back('{-16'sd10, 16'sd0, 0, 16'sd0});
      rows.push_back('{-16'sd11, 16'sd0, 0, 16'sd0});
      rows.push_back('{16'sh7FFF, 16'sh8000, 0, 16'sd0});
      rows.push_back('{16'sh7FFF, 16'sh8000, 0, 16'sd0});
      rows.push_back('{16'sh8000, 16'sh7FFF, 0, 16'sd0});
      rows.push_back('{16'sd5000, 16'sd4000, 0, 16'sd0});
      rows.push_back('{16'sd5000, 16'sd4001, 0, 16'sd0});
      rows.push_back('{16'sd5000, -16'sd4001, 0, 16'sd0});
      foreach (rows[k]) send_sample(rows[k].target, rows[k].measured, rows[k].known,
                                    rows[k].drive, 0);
      drain();
      rows.delete();
      write_reg(CSR_SAMPLE_PER, 24'd0);
      write_reg(CSR_INCR_MODE, 24'd1);
      rows.push_back('{16'sd300, 16'sd100, 0, 16'sd0});
      rows.push_back('{16'sd900, 16'sd100, 0, 16'sd0});
      rows.push_back('{16'sd0, 16'sd100, 1, 16'sd0});
      rows.push_back('{16'sd700, -16'sd5000, 0, 16'sd0});
      foreach (rows[k]) send_sample(rows[k].target, rows[k].measured, rows[k].known,
                                    rows[k].drive, 0);
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         random_setting(ph == 0);
         if (ph == 3) begin
            write_reg(CSR_OUTPUT_LIMIT, 24'd0);
            write_reg(CSR_SAMPLE_PER, 24'd65535);
         end
         if (ph == 5) hold_rsp = 1;
         base = pick_speed();
         for (int n = 0; n < 125; n++) begin
            if ($urandom_range(0, 3) == 0) base = pick_speed();
            send_sample($urandom_range(0, 7) == 0 ? 16'sd0 : base +
                        16'($signed($urandom_range(0, 400)) - 200),
                        pick_speed(), 0, 16'sd0, n % 40 < 30);
         end
         drain();
      end
      stim_done = 1;
      if (drive_queue.size() != 0) begin
         $display("simulation failed");
         $finish;
      end
      $display("Covered %0d request beats over %0d register settings, %0d responses checked.",
               beats_sent, settings_used, beats_checked);
      if (errors == 0 && drive_queue.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      int wait_cycles;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 0;
            hold_rsp = 0;
            repeat (400) @(posedge clock);
         end
         wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
         if (wait_cycles != 0) begin
            rsp_ready <= 0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         rsp_ready <= 0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (drive_queue.size() == 0) begin
            $error("response beat with nothing expected: drive_value %0d", rsp_drive_value);
            errors++;
         end else begin
            if (rsp_drive_value !== drive_queue[0]) begin
               $error("drive_value mismatch: expected %0d actual %0d",
                      drive_queue[0], rsp_drive_value);
               errors++;
            end
            void'(drive_queue.pop_front());
            beats_checked++;
         end
      end
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/spsl_pkg.sv
hdl/spsl_ctrl.sv
hdl/spsl_dp.sv
hdl/speed_pid_slew_limited_core.sv
tb/sv/tb_speed_pid_slew_limited_core.sv
